[sv/qwvs_pkg.sv]
// Shared constants for the quaternion skinning engine.
package qwvs_pkg;

    localparam int JOINT_SLOTS_DEF   = 256;
    localparam int WEIGHT_SLOTS_DEF  = 4096;
    localparam int MAX_WEIGHTS_DEF   = 16;

    localparam int IDX_W  = 17;
    localparam int ACC_W  = 51;
    localparam int JENT_W = 160;
    localparam int WENT_W = 120;

    localparam logic [1:0] CMD_JOINT  = 2'd0;
    localparam logic [1:0] CMD_WEIGHT = 2'd1;
    localparam logic [1:0] CMD_SKIN   = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_IDX = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

endpackage

[sv/quaternion_weighted_vertex_skinning.sv]
// Top level of the quaternion skinning engine.
// Usage: one input word per command on the in_valid/in_stall channel.
//   Load joint (command 0) writes a quaternion and a position into the joint
//   RAM; load weight (command 1) writes bone, bias and local position into the
//   weight RAM. Both give no output word.
//   Skin (command 2) walks weight_count weights (at most MAX_WEIGHTS_PER_VERTEX) from slot and emits one
//   vertex word on the out_valid/out_stall channel with a status code.
// Sequence: a skin command takes each weight through a weight RAM read, a joint
//   RAM read, then six datapath steps, and at the end loads the output
//   register with the vertex word; a weight skipped for a bad index leaves
//   at the weight RAM read or at the joint RAM read.
// Throughput: one command at a time; in_stall is high while a skin command
//   is in work or its result cannot yet be placed in the output register.
// Reset: control state clears; RAM contents stay undefined until loaded.
// A stalled output word holds; the engine waits in its final step until the
//   output register frees up.
module quaternion_weighted_vertex_skinning
    import qwvs_pkg::*;
#(
    parameter int JOINT_SLOTS            = JOINT_SLOTS_DEF,
    parameter int WEIGHT_SLOTS           = WEIGHT_SLOTS_DEF,
    parameter int MAX_WEIGHTS_PER_VERTEX = MAX_WEIGHTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [11:0]        slot,
    input  logic [4:0]         weight_count,
    input  logic [7:0]         bone_index,
    input  logic signed [15:0] bias,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z,
    output logic [1:0]         status
);

    localparam int JAW = (JOINT_SLOTS > 1) ? $clog2(JOINT_SLOTS) : 1;
    localparam int WAW = (WEIGHT_SLOTS > 1) ? $clog2(WEIGHT_SLOTS) : 1;
    localparam int CW  = $clog2(MAX_WEIGHTS_PER_VERTEX + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_WREAD, S_JREAD, S_QUAT, S_MAT, S_MVP, S_MODEL, S_BIAS, S_ACC, S_DONE
    } state_t;

    state_t state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CW-1:0]    left_reg;
    logic             err_reg;
    logic             out_valid_reg;
    logic signed [31:0] vx_out_reg, vy_out_reg, vz_out_reg;
    logic [1:0]       status_reg;
    logic signed [ACC_W-1:0] acc_reg [3];

    // datapath registers
    logic signed [31:0] v_reg [3];
    logic signed [15:0] bias_reg;
    logic signed [31:0] off_reg [3];
    logic signed [31:0] qp_reg [10];
    logic signed [26:0] m_reg [9];
    logic signed [58:0] p_reg [9];
    logic signed [41:0] model_reg [3];
    logic signed [57:0] bp_reg [3];

    logic accept;
    logic [IDX_W-1:0] slot_ext, bone_ext;
    logic [CW-1:0] count_c;
    logic j_we, w_we;
    logic [JAW-1:0] j_addr;
    logic [WAW-1:0] w_addr;
    logic [JENT_W-1:0] j_wdata, j_rdata;
    logic [WENT_W-1:0] w_wdata, w_rdata;
    logic out_free, last;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign slot_ext = {5'd0, slot};
    assign bone_ext = {9'd0, w_rdata[7:0]};
    assign count_c  = (32'(weight_count) > MAX_WEIGHTS_PER_VERTEX)
                      ? CW'(MAX_WEIGHTS_PER_VERTEX) : CW'(weight_count);
    assign out_free = !out_valid_reg || !out_stall;
    assign last     = (left_reg == CW'(1));

    assign j_we    = accept && (command == CMD_JOINT) && (32'(slot) < JOINT_SLOTS);
    assign w_we    = accept && (command == CMD_WEIGHT) && (32'(slot) < WEIGHT_SLOTS);
    assign j_addr  = (state_reg == S_IDLE) ? slot_ext[JAW-1:0] : bone_ext[JAW-1:0];
    assign w_addr  = (state_reg == S_IDLE) ? slot_ext[WAW-1:0] : idx_reg[WAW-1:0];
    assign j_wdata = {pos_z, pos_y, pos_x, quat_w, quat_z, quat_y, quat_x};
    assign w_wdata = {pos_z, pos_y, pos_x, bias, bone_index};

    qwvs_ram #(.WIDTH(JENT_W), .DEPTH(JOINT_SLOTS), .AW(JAW)) u_joint_ram (
        .clk   (clk),
        .we    (j_we),
        .addr  (j_addr),
        .wdata (j_wdata),
        .rdata (j_rdata)
    );

    qwvs_ram #(.WIDTH(WENT_W), .DEPTH(WEIGHT_SLOTS), .AW(WAW)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .addr  (w_addr),
        .wdata (w_wdata),
        .rdata (w_rdata)
    );

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] a);
        if (a > ACC_W'(signed'(33'sh0_7FFF_FFFF)))
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (a < -(ACC_W'(signed'(33'sh0_8000_0000))))
        begin
            return 32'sh8000_0000;
        end
        return a[31:0];
    endfunction

    function automatic logic is_sat(input logic signed [ACC_W-1:0] a);
        return (a > ACC_W'(signed'(33'sh0_7FFF_FFFF)))
            || (a < -(ACC_W'(signed'(33'sh0_8000_0000))));
    endfunction

    // rounded matrix entries: products are Q.28, entries kept at Q.20
    logic signed [34:0] mt [9];
    logic signed [34:0] mr [9];
    always_comb
    begin
        mt[0] = 35'(qp_reg[3]) + 35'(qp_reg[0]) - 35'(qp_reg[1]) - 35'(qp_reg[2]);
        mt[1] = (35'(qp_reg[4]) - 35'(qp_reg[9])) <<< 1;
        mt[2] = (35'(qp_reg[5]) + 35'(qp_reg[8])) <<< 1;
        mt[3] = (35'(qp_reg[4]) + 35'(qp_reg[9])) <<< 1;
        mt[4] = 35'(qp_reg[3]) - 35'(qp_reg[0]) + 35'(qp_reg[1]) - 35'(qp_reg[2]);
        mt[5] = (35'(qp_reg[6]) - 35'(qp_reg[7])) <<< 1;
        mt[6] = (35'(qp_reg[5]) - 35'(qp_reg[8])) <<< 1;
        mt[7] = (35'(qp_reg[6]) + 35'(qp_reg[7])) <<< 1;
        mt[8] = 35'(qp_reg[3]) - 35'(qp_reg[0]) - 35'(qp_reg[1]) + 35'(qp_reg[2]);
        for (int k = 0; k < 9; k++)
        begin
            mr[k] = (mt[k] + 35'sd128) >>> 8;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [15:0] qx, qy, qz, qw;
        logic signed [60:0] r;
        logic signed [40:0] rr;
        qx = signed'(j_rdata[15:0]);
        qy = signed'(j_rdata[31:16]);
        qz = signed'(j_rdata[47:32]);
        qw = signed'(j_rdata[63:48]);
        case (state_reg)
            S_JREAD:
            begin
                bias_reg <= signed'(w_rdata[23:8]);
                v_reg[0] <= signed'(w_rdata[55:24]);
                v_reg[1] <= signed'(w_rdata[87:56]);
                v_reg[2] <= signed'(w_rdata[119:88]);
            end
            S_QUAT:
            begin
                off_reg[0] <= signed'(j_rdata[95:64]);
                off_reg[1] <= signed'(j_rdata[127:96]);
                off_reg[2] <= signed'(j_rdata[159:128]);
                qp_reg[0] <= qx * qx;
                qp_reg[1] <= qy * qy;
                qp_reg[2] <= qz * qz;
                qp_reg[3] <= qw * qw;
                qp_reg[4] <= qx * qy;
                qp_reg[5] <= qx * qz;
                qp_reg[6] <= qy * qz;
                qp_reg[7] <= qw * qx;
                qp_reg[8] <= qw * qy;
                qp_reg[9] <= qw * qz;
            end
            S_MAT:
            begin
                for (int k = 0; k < 9; k++)
                begin
                    m_reg[k] <= mr[k][26:0];
                end
            end
            S_MVP:
            begin
                for (int k = 0; k < 9; k++)
                begin
                    p_reg[k] <= m_reg[k] * v_reg[k % 3];
                end
            end
            S_MODEL:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    r = 61'(p_reg[3*k]) + 61'(p_reg[3*k+1]) + 61'(p_reg[3*k+2]);
                    rr = 41'((r + 61'sd524288) >>> 20);
                    model_reg[k] <= 42'(rr) + 42'(off_reg[k]);
                end
            end
            S_BIAS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    bp_reg[k] <= model_reg[k] * bias_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
            idx_reg       <= '0;
            left_reg      <= '0;
            vx_out_reg    <= '0;
            vy_out_reg    <= '0;
            vz_out_reg    <= '0;
            status_reg    <= ST_OK;
            for (int k = 0; k < 3; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            // drop a taken word unless the final step reloads the register
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (command == CMD_SKIN))
                    begin
                        err_reg  <= 1'b0;
                        idx_reg  <= slot_ext;
                        left_reg <= count_c;
                        for (int k = 0; k < 3; k++)
                        begin
                            acc_reg[k] <= '0;
                        end
                        state_reg <= (count_c == '0) ? S_DONE : S_WREAD;
                    end
                end
                S_WREAD:
                begin
                    if (32'(idx_reg) >= WEIGHT_SLOTS)
                    begin
                        // skip: weight index past the table
                        err_reg   <= 1'b1;
                        idx_reg   <= idx_reg + IDX_W'(1);
                        left_reg  <= left_reg - CW'(1);
                        state_reg <= last ? S_DONE : S_WREAD;
                    end
                    else
                    begin
                        state_reg <= S_JREAD;
                    end
                end
                S_JREAD:
                begin
                    if (32'(bone_ext) >= JOINT_SLOTS)
                    begin
                        err_reg   <= 1'b1;
                        idx_reg   <= idx_reg + IDX_W'(1);
                        left_reg  <= left_reg - CW'(1);
                        state_reg <= last ? S_DONE : S_WREAD;
                    end
                    else
                    begin
                        state_reg <= S_QUAT;
                    end
                end
                S_QUAT:  state_reg <= S_MAT;
                S_MAT:   state_reg <= S_MVP;
                S_MVP:   state_reg <= S_MODEL;
                S_MODEL: state_reg <= S_BIAS;
                S_BIAS:  state_reg <= S_ACC;
                S_ACC:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        acc_reg[k] <= acc_reg[k] + ACC_W'((bp_reg[k] + 58'sd8192) >>> 14);
                    end
                    idx_reg   <= idx_reg + IDX_W'(1);
                    left_reg  <= left_reg - CW'(1);
                    state_reg <= last ? S_DONE : S_WREAD;
                end
                S_DONE:
                begin
                    // hold until the output register frees up
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        vx_out_reg    <= sat32(acc_reg[0]);
                        vy_out_reg    <= sat32(acc_reg[1]);
                        vz_out_reg    <= sat32(acc_reg[2]);
                        if (err_reg)
                        begin
                            status_reg <= ST_IDX;
                        end
                        else if (is_sat(acc_reg[0]) || is_sat(acc_reg[1])
                                 || is_sat(acc_reg[2]))
                        begin
                            status_reg <= ST_SAT;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign vertex_x  = vx_out_reg;
    assign vertex_y  = vy_out_reg;
    assign vertex_z  = vz_out_reg;
    assign status    = status_reg;

endmodule

[sv/qwvs_ram.sv]
// Generic single-port RAM with registered read.
module qwvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
